>>> sv/segment_box_clipper_macros.svh
// Assertion macros for the segment box clipper.
// Taken in by the top level; no other dependencies.
`ifndef SEGMENT_BOX_CLIPPER_MACROS_SVH
`define SEGMENT_BOX_CLIPPER_MACROS_SVH
`ifndef SYNTHESIS
`define SBC_ASSERT_HOLD(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbc: same-cycle check failed");
`define SBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbc: next-cycle check failed");
`else
`define SBC_ASSERT_HOLD(label, clk, rst_n, ante, cons)
`define SBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/sbc_pkg.sv
// Shared constants and types of the segment box clipper.
// No dependencies.
`timescale 1ns / 1ps
package sbc_pkg;

	localparam int NUM_LANES    = 4;
	localparam int LANE_START_X = 0;
	localparam int LANE_START_Z = 1;
	localparam int LANE_END_X   = 2;
	localparam int LANE_END_Z   = 3;

	localparam int AXIS_X = 0;
	localparam int AXIS_Z = 1;

	localparam int CFG_INDEX_BITS = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_BOX_MIN_X = 2'd0,
		REG_BOX_MIN_Z = 2'd1,
		REG_BOX_MAX_X = 2'd2,
		REG_BOX_MAX_Z = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic visible;
		logic start_inside;
		logic end_inside;
	} sbc_flags_t;

endpackage

>>> sv/sbc_if.sv
// Stream interfaces of the segment box clipper: segment in, clip result out.
// No dependencies.
`timescale 1ns / 1ps
interface sbc_seg_if #(parameter int COORD_BITS = 32);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] ax;
	logic signed [COORD_BITS-1:0] az;
	logic signed [COORD_BITS-1:0] bx;
	logic signed [COORD_BITS-1:0] bz;
	modport source (output valid, output ax, output az, output bx, output bz, input ready);
	modport sink (input valid, input ax, input az, input bx, input bz, output ready);
endinterface

interface sbc_clip_if #(parameter int COORD_BITS = 32);
	logic valid;
	logic ready;
	logic visible;
	logic signed [COORD_BITS-1:0] clip_start_x;
	logic signed [COORD_BITS-1:0] clip_start_z;
	logic signed [COORD_BITS-1:0] clip_end_x;
	logic signed [COORD_BITS-1:0] clip_end_z;
	logic start_was_inside;
	logic end_was_inside;
	modport source (output valid, output visible, output clip_start_x, output clip_start_z,
		output clip_end_x, output clip_end_z, output start_was_inside,
		output end_was_inside, input ready);
	modport sink (input valid, input visible, input clip_start_x, input clip_start_z,
		input clip_end_x, input clip_end_z, input start_was_inside,
		input end_was_inside, output ready);
endinterface

>>> sv/sbc_front.sv
// Front pipeline: edge parameters, clamping, entry/exit selection, products.
// Depends on sbc_pkg.
`timescale 1ns / 1ps
module sbc_front #(
	parameter int COORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] az,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] bz,
	input  logic signed [COORD_BITS-1:0] box_min_x,
	input  logic signed [COORD_BITS-1:0] box_min_z,
	input  logic signed [COORD_BITS-1:0] box_max_x,
	input  logic signed [COORD_BITS-1:0] box_max_z,
	output logic out_valid,
	input  logic out_ready,
	output logic [sbc_pkg::NUM_LANES-1:0][2*COORD_BITS-1:0] num,
	output logic [sbc_pkg::NUM_LANES-1:0][COORD_BITS-1:0] den,
	output logic [sbc_pkg::NUM_LANES-1:0] neg,
	output logic [sbc_pkg::NUM_LANES-1:0][COORD_BITS-1:0] orig,
	output sbc_pkg::sbc_flags_t flags
);
	localparam int W = COORD_BITS;
	localparam int X = sbc_pkg::AXIS_X;
	localparam int Z = sbc_pkg::AXIS_Z;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// stage 1: deltas and distances to the box edges
	logic [1:0][W:0] d_c, ql_c, qh_c;
	logic [1:0][W:0] d_s1, ql_s1, qh_s1;
	logic [1:0][W-1:0] a_s1;
	logic a_in_s1, b_in_s1;

	always_comb begin
		d_c[X]  = {bx[W-1], bx} - {ax[W-1], ax};
		d_c[Z]  = {bz[W-1], bz} - {az[W-1], az};
		ql_c[X] = {ax[W-1], ax} - {box_min_x[W-1], box_min_x};
		ql_c[Z] = {az[W-1], az} - {box_min_z[W-1], box_min_z};
		qh_c[X] = {box_max_x[W-1], box_max_x} - {ax[W-1], ax};
		qh_c[Z] = {box_max_z[W-1], box_max_z} - {az[W-1], az};
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			d_s1    <= d_c;
			ql_s1   <= ql_c;
			qh_s1   <= qh_c;
			a_s1[X] <= ax;
			a_s1[Z] <= az;
			a_in_s1 <= (ax >= box_min_x) && (ax <= box_max_x) &&
				(az >= box_min_z) && (az <= box_max_z);
			b_in_s1 <= (bx >= box_min_x) && (bx <= box_max_x) &&
				(bz >= box_min_z) && (bz <= box_max_z);
		end
	end

	// stage 2: direction magnitude and raw entry/exit numerators
	logic [1:0][W-1:0] mag_c;
	logic [1:0][W:0] lraw_c, hraw_c;
	logic [1:0][W-1:0] mag_s2;
	logic [1:0][W:0] lraw_s2, hraw_s2;
	logic [1:0] zero_s2, zpass_s2, neg_s2;
	logic [1:0][W-1:0] a_s2;
	logic a_in_s2, b_in_s2;

	for (genvar i = 0; i < 2; i++) begin : g_axis2
		logic [W:0] dneg;
		always_comb begin
			dneg      = '0 - d_s1[i];
			mag_c[i]  = d_s1[i][W] ? dneg[W-1:0] : d_s1[i][W-1:0];
			// going backwards swaps which edge is entered first
			lraw_c[i] = d_s1[i][W] ? ('0 - qh_s1[i]) : ('0 - ql_s1[i]);
			hraw_c[i] = d_s1[i][W] ? ql_s1[i] : qh_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			mag_s2   <= mag_c;
			lraw_s2  <= lraw_c;
			hraw_s2  <= hraw_c;
			zero_s2[X]  <= (d_s1[X] == '0);
			zero_s2[Z]  <= (d_s1[Z] == '0);
			zpass_s2[X] <= !ql_s1[X][W] && !qh_s1[X][W];
			zpass_s2[Z] <= !ql_s1[Z][W] && !qh_s1[Z][W];
			neg_s2[X]   <= d_s1[X][W];
			neg_s2[Z]   <= d_s1[Z][W];
			a_s2     <= a_s1;
			a_in_s2  <= a_in_s1;
			b_in_s2  <= b_in_s1;
		end
	end

	// stage 3: clamp each axis interval to [0, 1]; flag an empty one
	logic [1:0][W-1:0] ln_c, hn_c, dn_c;
	logic [1:0] bad_c;
	logic [1:0][W-1:0] ln_s3, hn_s3, dn_s3, mag_s3;
	logic [1:0] neg_s3;
	logic [1:0][W-1:0] a_s3;
	logic bad_s3, a_in_s3, b_in_s3;

	for (genvar i = 0; i < 2; i++) begin : g_axis3
		logic lbad;
		always_comb begin
			lbad = !lraw_s2[i][W] && (lraw_s2[i][W-1:0] > mag_s2[i]);
			if (zero_s2[i]) begin
				ln_c[i]  = '0;
				hn_c[i]  = W'(1);
				dn_c[i]  = W'(1);
				bad_c[i] = !zpass_s2[i];
			end else begin
				ln_c[i] = lraw_s2[i][W] ? '0 : (lbad ? mag_s2[i] : lraw_s2[i][W-1:0]);
				if (hraw_s2[i][W])
					hn_c[i] = '0;
				else if (hraw_s2[i][W-1:0] > mag_s2[i])
					hn_c[i] = mag_s2[i];
				else
					hn_c[i] = hraw_s2[i][W-1:0];
				dn_c[i]  = mag_s2[i];
				bad_c[i] = lbad || hraw_s2[i][W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ln_s3   <= ln_c;
			hn_s3   <= hn_c;
			dn_s3   <= dn_c;
			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			a_s3    <= a_s2;
			bad_s3  <= |bad_c;
			a_in_s3 <= a_in_s2;
			b_in_s3 <= b_in_s2;
		end
	end

	// stage 4: cross products to compare the axis fractions
	logic [2*W-1:0] plx_s4, plz_s4, phx_s4, phz_s4;
	logic [1:0][W-1:0] ln_s4, hn_s4, dn_s4, mag_s4;
	logic [1:0] neg_s4;
	logic [1:0][W-1:0] a_s4;
	logic bad_s4, a_in_s4, b_in_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			plx_s4  <= (2*W)'(ln_s3[X]) * (2*W)'(dn_s3[Z]);
			plz_s4  <= (2*W)'(ln_s3[Z]) * (2*W)'(dn_s3[X]);
			phx_s4  <= (2*W)'(hn_s3[X]) * (2*W)'(dn_s3[Z]);
			phz_s4  <= (2*W)'(hn_s3[Z]) * (2*W)'(dn_s3[X]);
			ln_s4   <= ln_s3;
			hn_s4   <= hn_s3;
			dn_s4   <= dn_s3;
			mag_s4  <= mag_s3;
			neg_s4  <= neg_s3;
			a_s4    <= a_s3;
			bad_s4  <= bad_s3;
			a_in_s4 <= a_in_s3;
			b_in_s4 <= b_in_s3;
		end
	end

	// stage 5: entry is the later fraction, exit the earlier
	logic lsel_x, hsel_x;
	logic [W-1:0] lo_n_s5, lo_d_s5, hi_n_s5, hi_d_s5;
	logic [1:0][W-1:0] mag_s5;
	logic [1:0] neg_s5;
	logic [1:0][W-1:0] a_s5;
	logic bad_s5, a_in_s5, b_in_s5;

	assign lsel_x = (plx_s4 >= plz_s4);
	assign hsel_x = (phx_s4 <= phz_s4);

	always_ff @(posedge clk) begin
		if (en_s5) begin
			lo_n_s5 <= lsel_x ? ln_s4[X] : ln_s4[Z];
			lo_d_s5 <= lsel_x ? dn_s4[X] : dn_s4[Z];
			hi_n_s5 <= hsel_x ? hn_s4[X] : hn_s4[Z];
			hi_d_s5 <= hsel_x ? dn_s4[X] : dn_s4[Z];
			mag_s5  <= mag_s4;
			neg_s5  <= neg_s4;
			a_s5    <= a_s4;
			bad_s5  <= bad_s4;
			a_in_s5 <= a_in_s4;
			b_in_s5 <= b_in_s4;
		end
	end

	// stage 6: entry vs exit products and the four point products
	logic [2*W-1:0] pvl_s6, pvh_s6;
	logic [sbc_pkg::NUM_LANES-1:0][2*W-1:0] pc_s6;
	logic [W-1:0] lo_d_s6, hi_d_s6;
	logic [1:0] neg_s6;
	logic [1:0][W-1:0] a_s6;
	logic bad_s6, a_in_s6, b_in_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			pvl_s6 <= (2*W)'(lo_n_s5) * (2*W)'(hi_d_s5);
			pvh_s6 <= (2*W)'(hi_n_s5) * (2*W)'(lo_d_s5);
			pc_s6[sbc_pkg::LANE_START_X] <= (2*W)'(lo_n_s5) * (2*W)'(mag_s5[X]);
			pc_s6[sbc_pkg::LANE_START_Z] <= (2*W)'(lo_n_s5) * (2*W)'(mag_s5[Z]);
			pc_s6[sbc_pkg::LANE_END_X]   <= (2*W)'(hi_n_s5) * (2*W)'(mag_s5[X]);
			pc_s6[sbc_pkg::LANE_END_Z]   <= (2*W)'(hi_n_s5) * (2*W)'(mag_s5[Z]);
			lo_d_s6 <= lo_d_s5;
			hi_d_s6 <= hi_d_s5;
			neg_s6  <= neg_s5;
			a_s6    <= a_s5;
			bad_s6  <= bad_s5;
			a_in_s6 <= a_in_s5;
			b_in_s6 <= b_in_s5;
		end
	end

	always_comb begin
		num = pc_s6;
		den[sbc_pkg::LANE_START_X]  = lo_d_s6;
		den[sbc_pkg::LANE_START_Z]  = lo_d_s6;
		den[sbc_pkg::LANE_END_X]    = hi_d_s6;
		den[sbc_pkg::LANE_END_Z]    = hi_d_s6;
		neg[sbc_pkg::LANE_START_X]  = neg_s6[X];
		neg[sbc_pkg::LANE_START_Z]  = neg_s6[Z];
		neg[sbc_pkg::LANE_END_X]    = neg_s6[X];
		neg[sbc_pkg::LANE_END_Z]    = neg_s6[Z];
		orig[sbc_pkg::LANE_START_X] = a_s6[X];
		orig[sbc_pkg::LANE_START_Z] = a_s6[Z];
		orig[sbc_pkg::LANE_END_X]   = a_s6[X];
		orig[sbc_pkg::LANE_END_Z]   = a_s6[Z];
		flags.visible      = !bad_s6 && (pvl_s6 <= pvh_s6);
		flags.start_inside = a_in_s6;
		flags.end_inside   = b_in_s6;
	end

endmodule

>>> sv/sbc_div.sv
// Pipelined restoring divider, one quotient bit per stage, four lanes.
// Depends on sbc_pkg; carries a sideband vector alongside.
`timescale 1ns / 1ps
module sbc_div #(
	parameter int COORD_BITS = 32,
	parameter int SIDE_BITS  = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [sbc_pkg::NUM_LANES-1:0][2*COORD_BITS-1:0] num,
	input  logic [sbc_pkg::NUM_LANES-1:0][COORD_BITS-1:0] den,
	input  logic [SIDE_BITS-1:0] side,
	output logic out_valid,
	input  logic out_ready,
	output logic [sbc_pkg::NUM_LANES-1:0][COORD_BITS-1:0] quo,
	output logic [sbc_pkg::NUM_LANES-1:0][COORD_BITS-1:0] rem,
	output logic [sbc_pkg::NUM_LANES-1:0][COORD_BITS-1:0] den_o,
	output logic [SIDE_BITS-1:0] side_o
);
	localparam int W = COORD_BITS;
	localparam int L = sbc_pkg::NUM_LANES;

	// remainder and the shifting dividend/quotient word of each stage
	logic [L-1:0][W-1:0] rem_s [W+1];
	logic [L-1:0][W-1:0] low_s [W+1];
	logic [L-1:0][W-1:0] den_s [W+1];
	logic [SIDE_BITS-1:0] side_s [W+1];
	logic vld_s [W+1];
	logic en_s [W+1];

	// upper half is below the divisor, so W steps give the whole quotient
	always_comb begin
		for (int l = 0; l < L; l++) begin
			rem_s[0][l] = num[l][2*W-1:W];
			low_s[0][l] = num[l][W-1:0];
		end
	end
	assign den_s[0]  = den;
	assign side_s[0] = side;
	assign vld_s[0]  = in_valid;
	assign en_s[0]   = en_s[1];
	assign in_ready  = en_s[0];

	for (genvar k = 1; k <= W; k++) begin : g_stage
		logic [L-1:0][W-1:0] rem_c, low_c;

		always_comb begin
			logic [W:0] trial;
			logic [W:0] diff;
			logic ge;
			for (int l = 0; l < L; l++) begin
				trial    = {rem_s[k-1][l], low_s[k-1][l][W-1]};
				diff     = trial - {1'b0, den_s[k-1][l]};
				ge       = (trial >= {1'b0, den_s[k-1][l]});
				rem_c[l] = ge ? diff[W-1:0] : trial[W-1:0];
				low_c[l] = {low_s[k-1][l][W-2:0], ge};
			end
		end

		if (k == W) begin : g_last
			assign en_s[k] = !vld_s[k] || out_ready;
		end else begin : g_mid
			assign en_s[k] = !vld_s[k] || en_s[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en_s[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en_s[k]) begin
				rem_s[k]  <= rem_c;
				low_s[k]  <= low_c;
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[W];
	assign quo       = low_s[W];
	assign rem       = rem_s[W];
	assign den_o     = den_s[W];
	assign side_o    = side_s[W];

endmodule

>>> sv/sbc_round.sv
// Rounding stages: floor quotient to half-away-from-zero point coordinates.
// Depends on sbc_pkg; the second stage is the output register.
`timescale 1ns / 1ps
module sbc_round #(
	parameter int COORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [sbc_pkg::NUM_LANES-1:0][COORD_BITS-1:0] quo,
	input  logic [sbc_pkg::NUM_LANES-1:0][COORD_BITS-1:0] rem,
	input  logic [sbc_pkg::NUM_LANES-1:0][COORD_BITS-1:0] den,
	input  logic [sbc_pkg::NUM_LANES-1:0] neg,
	input  logic [sbc_pkg::NUM_LANES-1:0][COORD_BITS-1:0] orig,
	input  sbc_pkg::sbc_flags_t flags,
	output logic out_valid,
	input  logic out_ready,
	output logic [sbc_pkg::NUM_LANES-1:0][COORD_BITS-1:0] coord,
	output sbc_pkg::sbc_flags_t flags_o
);
	localparam int W = COORD_BITS;
	localparam int L = sbc_pkg::NUM_LANES;

	logic v_s1, v_s2, en_s1, en_s2;

	assign en_s2     = !v_s2 || out_ready;
	assign en_s1     = !v_s1 || en_s2;
	assign in_ready  = en_s1;
	assign out_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	logic [L-1:0][W+1:0] base_c, base_s1;
	logic [L-1:0][W-1:0] rr_c, rr_s1, den_s1;
	logic [L-1:0][W-1:0] coord_c, coord_s2;
	sbc_pkg::sbc_flags_t flags_s1, flags_s2;

	for (genvar l = 0; l < L; l++) begin : g_lane
		// stage 1: floor quotient with non-negative remainder, plus start coordinate
		always_comb begin
			logic rnz;
			logic [W:0] qf;
			rnz = (rem[l] != '0);
			if (!neg[l]) begin
				qf       = {1'b0, quo[l]};
				rr_c[l]  = rem[l];
			end else if (rnz) begin
				qf       = ~{1'b0, quo[l]};
				rr_c[l]  = den[l] - rem[l];
			end else begin
				qf       = '0 - {1'b0, quo[l]};
				rr_c[l]  = '0;
			end
			base_c[l] = {orig[l][W-1], orig[l][W-1], orig[l]} + {qf[W], qf};
		end

		// stage 2: round up past half, and at half when the floor is not negative
		always_comb begin
			logic [W:0] twice;
			logic up;
			logic [W+1:0] res;
			twice = {rr_s1[l], 1'b0};
			up    = (twice > {1'b0, den_s1[l]}) ||
				((twice == {1'b0, den_s1[l]}) && !base_s1[l][W+1]);
			res   = base_s1[l] + (W+2)'(up);
			coord_c[l] = flags_s1.visible ? res[W-1:0] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			base_s1  <= base_c;
			rr_s1    <= rr_c;
			den_s1   <= den;
			flags_s1 <= flags;
		end
		if (en_s2) begin
			coord_s2 <= coord_c;
			flags_s2 <= flags_s1;
		end
	end

	assign coord   = coord_s2;
	assign flags_o = flags_s2;

endmodule

>>> sv/segment_box_clipper.sv
// Top level of the segment box clipper: clip box registers and the pipeline.
// Depends on sbc_pkg, sbc_if, sbc_front, sbc_div, sbc_round and the macro header.
//
//   channel  dir  handshake            word
//   seg      in   seg.valid/ready      ax, az, bx, bz
//   clip     out  clip.valid/ready     visible, clipped points, inside flags
//   cfg      in   cfg_we               cfg_index, cfg_data (no read-back)
//
// One segment per cycle unless the output stalls; the pipeline is six front stages,
// one divider stage per quotient bit and two rounding stages.
// Reset clears all valid bits and the box registers to zero.
// Each stage holds while its successor is full and stalled; empty stages still fill.
`timescale 1ns / 1ps
`include "segment_box_clipper_macros.svh"
module segment_box_clipper #(
	parameter int COORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	sbc_seg_if.sink seg,
	sbc_clip_if.source clip,
	input  logic cfg_we,
	input  logic [sbc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data
);
	localparam int W = COORD_BITS;
	localparam int L = sbc_pkg::NUM_LANES;
	localparam int FLAG_BITS = $bits(sbc_pkg::sbc_flags_t);
	localparam int SIDE_BITS = L * (W + 1) + FLAG_BITS;

	logic signed [W-1:0] box_min_x_q, box_min_z_q, box_max_x_q, box_max_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_x_q <= '0;
			box_min_z_q <= '0;
			box_max_x_q <= '0;
			box_max_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sbc_pkg::REG_BOX_MIN_X: box_min_x_q <= cfg_data;
				sbc_pkg::REG_BOX_MIN_Z: box_min_z_q <= cfg_data;
				sbc_pkg::REG_BOX_MAX_X: box_max_x_q <= cfg_data;
				sbc_pkg::REG_BOX_MAX_Z: box_max_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic fr_valid, fr_ready;
	logic [L-1:0][2*W-1:0] fr_num;
	logic [L-1:0][W-1:0] fr_den, fr_orig;
	logic [L-1:0] fr_neg;
	sbc_pkg::sbc_flags_t fr_flags;

	sbc_front #(.COORD_BITS(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seg.valid),
		.in_ready  (seg.ready),
		.ax        (seg.ax),
		.az        (seg.az),
		.bx        (seg.bx),
		.bz        (seg.bz),
		.box_min_x (box_min_x_q),
		.box_min_z (box_min_z_q),
		.box_max_x (box_max_x_q),
		.box_max_z (box_max_z_q),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.num       (fr_num),
		.den       (fr_den),
		.neg       (fr_neg),
		.orig      (fr_orig),
		.flags     (fr_flags)
	);

	// pack start coordinate, sign and flags to ride along the divider
	logic [SIDE_BITS-1:0] fr_side, dv_side;
	logic dv_valid, dv_ready;
	logic [L-1:0][W-1:0] dv_quo, dv_rem, dv_den, dv_orig;
	logic [L-1:0] dv_neg;
	sbc_pkg::sbc_flags_t dv_flags;

	for (genvar l = 0; l < L; l++) begin : g_side
		assign fr_side[l*(W+1) +: W+1] = {fr_neg[l], fr_orig[l]};
		assign dv_neg[l]  = dv_side[l*(W+1) + W];
		assign dv_orig[l] = dv_side[l*(W+1) +: W];
	end
	assign fr_side[SIDE_BITS-1 -: FLAG_BITS] = fr_flags;
	assign dv_flags = sbc_pkg::sbc_flags_t'(dv_side[SIDE_BITS-1 -: FLAG_BITS]);

	sbc_div #(.COORD_BITS(W), .SIDE_BITS(SIDE_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.num       (fr_num),
		.den       (fr_den),
		.side      (fr_side),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.quo       (dv_quo),
		.rem       (dv_rem),
		.den_o     (dv_den),
		.side_o    (dv_side)
	);

	logic [L-1:0][W-1:0] rd_coord;
	sbc_pkg::sbc_flags_t rd_flags;

	sbc_round #(.COORD_BITS(W)) u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid),
		.in_ready  (dv_ready),
		.quo       (dv_quo),
		.rem       (dv_rem),
		.den       (dv_den),
		.neg       (dv_neg),
		.orig      (dv_orig),
		.flags     (dv_flags),
		.out_valid (clip.valid),
		.out_ready (clip.ready),
		.coord     (rd_coord),
		.flags_o   (rd_flags)
	);

	assign clip.visible          = rd_flags.visible;
	assign clip.start_was_inside = rd_flags.start_inside;
	assign clip.end_was_inside   = rd_flags.end_inside;
	assign clip.clip_start_x     = rd_coord[sbc_pkg::LANE_START_X];
	assign clip.clip_start_z     = rd_coord[sbc_pkg::LANE_START_Z];
	assign clip.clip_end_x       = rd_coord[sbc_pkg::LANE_END_X];
	assign clip.clip_end_z       = rd_coord[sbc_pkg::LANE_END_Z];

	// a free output frees every stage back to the input
	`SBC_ASSERT_HOLD(a_ready_chain, clk, arst_n, clip.ready, seg.ready)
	// an endpoint inside the box always leaves something visible
	`SBC_ASSERT_HOLD(a_start_visible, clk, arst_n, clip.valid && clip.start_was_inside, clip.visible)
	`SBC_ASSERT_HOLD(a_end_visible, clk, arst_n, clip.valid && clip.end_was_inside, clip.visible)
	`SBC_ASSERT_NEXT(a_cfg_min_x, clk, arst_n, cfg_we && cfg_index == sbc_pkg::REG_BOX_MIN_X, box_min_x_q == $past(cfg_data))

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for segment_box_clipper: directed and random segments
// against an in-bench clip predictor. Depends on sbc_pkg, sbc_if and the RTL.
`timescale 1ns / 1ps
module tb_top;

	localparam int CB = 32;
	localparam int LATENCY = CB + 8;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
	localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};

	typedef struct {
		logic visible;
		logic signed [CB-1:0] sx, sz, ex, ez;
		logic start_in, end_in;
	} clip_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [sbc_pkg::CFG_INDEX_BITS-1:0] cfg_index = sbc_pkg::REG_BOX_MIN_X;
	logic [CB-1:0] cfg_data = '0;

	sbc_seg_if #(CB) seg_ch();
	sbc_clip_if #(CB) clip_ch();

	segment_box_clipper #(.COORD_BITS(CB)) dut (
		.clk(clk), .arst_n(arst_n), .seg(seg_ch), .clip(clip_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic signed [CB-1:0] box_lo_x, box_lo_z, box_hi_x, box_hi_z;
	clip_word_t pending_clips[$];
	int fail_count = 0;
	int cycles = 0;
	bit calm = 0;
	bit hold_req = 0;
	int hold_left = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		seg_ch.valid = 1'b0;
		seg_ch.ax = '0;
		seg_ch.az = '0;
		seg_ch.bx = '0;
		seg_ch.bz = '0;
		clip_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left <= 300;
			clip_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			clip_ch.ready <= 1'b0;
		end else begin
			clip_ch.ready <= calm || ($urandom_range(99) >= 21);
		end
	end

	// ---------------- clip predictor ----------------
	function automatic int frac_cmp(longint rn, longint rd, longint sn, longint sd);
		logic signed [127:0] a, b, c, d;
		a = rn; b = sd; c = sn; d = rd;
		a = a * b;
		c = c * d;
		return (a > c) ? 1 : ((a < c) ? -1 : 0);
	endfunction

	function automatic bit clip_edge(longint p, longint q, inout longint lo_n, inout longint lo_d,
			inout longint hi_n, inout longint hi_d);
		longint rn, rd;
		if (p == 0)
			return q >= 0;
		if (p < 0) begin
			rn = -q;
			rd = -p;
			if (frac_cmp(rn, rd, hi_n, hi_d) > 0)
				return 0;
			if (frac_cmp(rn, rd, lo_n, lo_d) > 0) begin
				lo_n = rn;
				lo_d = rd;
			end
		end else begin
			rn = q;
			rd = p;
			if (frac_cmp(rn, rd, lo_n, lo_d) < 0)
				return 0;
			if (frac_cmp(rn, rd, hi_n, hi_d) < 0) begin
				hi_n = rn;
				hi_d = rd;
			end
		end
		return 1;
	endfunction

	// round a + (n/d)*delta half away from zero
	function automatic logic [CB-1:0] lerp_round(longint a, longint delta, longint n, longint d);
		logic signed [127:0] num, t, dd, quo, rem;
		bit neg;
		num = a;
		dd = d;
		num = num * dd;
		t = n;
		num = num + t * delta;
		neg = num < 0;
		if (neg)
			num = -num;
		quo = num / dd;
		rem = num % dd;
		if (2 * rem >= dd)
			quo = quo + 1;
		if (neg)
			quo = -quo;
		return quo[CB-1:0];
	endfunction

	function automatic bit in_box(longint x, longint z);
		return x >= box_lo_x && x <= box_hi_x && z >= box_lo_z && z <= box_hi_z;
	endfunction

	function automatic clip_word_t predict_clip(longint ax, longint az, longint bx, longint bz);
		clip_word_t w;
		longint dx, dz, lo_n, lo_d, hi_n, hi_d;
		bit vis;
		dx = bx - ax;
		dz = bz - az;
		lo_n = 0; lo_d = 1; hi_n = 1; hi_d = 1;
		vis = clip_edge(-dx, ax - box_lo_x, lo_n, lo_d, hi_n, hi_d);
		if (vis) vis = clip_edge(dx, box_hi_x - ax, lo_n, lo_d, hi_n, hi_d);
		if (vis) vis = clip_edge(-dz, az - box_lo_z, lo_n, lo_d, hi_n, hi_d);
		if (vis) vis = clip_edge(dz, box_hi_z - az, lo_n, lo_d, hi_n, hi_d);
		if (vis) vis = frac_cmp(lo_n, lo_d, hi_n, hi_d) <= 0;
		w.visible = vis;
		w.sx = vis ? lerp_round(ax, dx, lo_n, lo_d) : '0;
		w.sz = vis ? lerp_round(az, dz, lo_n, lo_d) : '0;
		w.ex = vis ? lerp_round(ax, dx, hi_n, hi_d) : '0;
		w.ez = vis ? lerp_round(az, dz, hi_n, hi_d) : '0;
		w.start_in = in_box(ax, az);
		w.end_in = in_box(bx, bz);
		return w;
	endfunction

	// ---------------- result checker ----------------
	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		clip_word_t w;
		if (arst_n && clip_ch.valid && clip_ch.ready) begin
			if (pending_clips.size() == 0) begin
				$error("clip word with no segment pending");
				fail_count++;
			end else begin
				w = pending_clips.pop_front();
				check_field("visible", w.visible, clip_ch.visible);
				check_field("clip_start_x", w.sx, clip_ch.clip_start_x);
				check_field("clip_start_z", w.sz, clip_ch.clip_start_z);
				check_field("clip_end_x", w.ex, clip_ch.clip_end_x);
				check_field("clip_end_z", w.ez, clip_ch.clip_end_z);
				check_field("start_was_inside", w.start_in, clip_ch.start_was_inside);
				check_field("end_was_inside", w.end_in, clip_ch.end_was_inside);
			end
		end
	end

	// ---------------- stimulus helpers ----------------
	task automatic send_segment(logic signed [CB-1:0] ax, logic signed [CB-1:0] az,
			logic signed [CB-1:0] bx, logic signed [CB-1:0] bz);
		if (!calm && $urandom_range(99) < 21) begin
			seg_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		seg_ch.valid <= 1'b1;
		seg_ch.ax <= ax;
		seg_ch.az <= az;
		seg_ch.bx <= bx;
		seg_ch.bz <= bz;
		do @(posedge clk); while (!seg_ch.ready);
		pending_clips.insert(pending_clips.size(), predict_clip(ax, az, bx, bz));
	endtask

	// drop valid and hold until every clip word is back
	task automatic drain_clips();
		seg_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_clips.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(sbc_pkg::reg_index_t idx, logic [CB-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic write_box(logic signed [CB-1:0] x0, logic signed [CB-1:0] z0,
			logic signed [CB-1:0] x1, logic signed [CB-1:0] z1);
		drain_clips();
		write_reg(sbc_pkg::REG_BOX_MIN_X, x0);
		write_reg(sbc_pkg::REG_BOX_MIN_Z, z0);
		write_reg(sbc_pkg::REG_BOX_MAX_X, x1);
		write_reg(sbc_pkg::REG_BOX_MAX_Z, z1);
		cfg_we <= 1'b0;
		box_lo_x = x0;
		box_lo_z = z0;
		box_hi_x = x1;
		box_hi_z = z1;
		@(posedge clk);
	endtask

	function automatic logic signed [CB-1:0] pick_coord(logic signed [CB-1:0] lo,
			logic signed [CB-1:0] hi);
		case ($urandom_range(5))
			0: return $urandom;
			1: return lo + $signed($urandom_range(0, 16)) - 8;
			2: return hi + $signed($urandom_range(0, 16)) - 8;
			3: return $urandom_range(1) ? CMIN : CMAX;
			default: return lo + (hi - lo) / 2 + $signed($urandom_range(0, 400)) - 200;
		endcase
	endfunction

	// ---------------- tests ----------------
	task automatic test_reset_box();
		box_lo_x = 0; box_lo_z = 0; box_hi_x = 0; box_hi_z = 0;
		send_segment(0, 0, 0, 0);
		send_segment(-5, -5, 5, 5);
		send_segment(1, 0, 2, 0);
	endtask

	task automatic test_directed();
		write_box(-100, -50, 100, 50);
		send_segment(-10, -10, 10, 10);
		send_segment(-200, 0, 200, 0);
		send_segment(200, 0, -200, 0);
		send_segment(-200, 60, 200, 60);
		send_segment(5, -200, 5, 200);
		send_segment(150, -10, 150, 10);
		send_segment(3, 4, 3, 4);
		send_segment(300, 4, 300, 4);
		send_segment(100, 50, 200, 100);
		send_segment(-101, 0, -99, 1);
		send_segment(-101, 0, -99, -1);
		send_segment(CMIN, CMIN, CMAX, CMAX);
		send_segment(CMAX, CMIN, CMIN, CMAX);
		send_segment(CMIN, 0, CMIN, 0);
		// inverted box: never visible
		write_box(10, 10, -10, -10);
		send_segment(0, 0, 5, 5);
		send_segment(-20, 0, 20, 0);
		write_box(CMIN, CMIN, CMAX, CMAX);
		send_segment(CMIN, CMAX, CMAX, CMIN);
		send_segment(CMAX, CMAX, CMAX, CMAX);
		send_segment(-1, 0, 1, 0);
	endtask

	task automatic test_backpressure();
		write_box(-1000, -1000, 1000, 1000);
		hold_req = 1;
		repeat (120)
			send_segment(pick_coord(-1000, 1000), pick_coord(-1000, 1000),
				pick_coord(-1000, 1000), pick_coord(-1000, 1000));
		drain_clips();
	endtask

	task automatic test_random();
		logic signed [CB-1:0] x0, z0, x1, z1;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin x0 = CMIN; z0 = CMIN; x1 = CMAX; z1 = CMAX; end
				1: begin x0 = 7; z0 = -3; x1 = 7; z1 = -3; end
				2: begin x0 = CMAX; z0 = CMAX; x1 = CMIN; z1 = CMIN; end
				default: begin
					x0 = $urandom; z0 = $urandom;
					x1 = x0 + $signed($urandom_range(0, 5000)) - 200;
					z1 = z0 + $signed($urandom_range(0, 5000)) - 200;
				end
			endcase
			write_box(x0, z0, x1, z1);
			calm = (phase == 4);
			repeat (85)
				send_segment(pick_coord(x0, x1), pick_coord(z0, z1),
					pick_coord(x0, x1), pick_coord(z0, z1));
			calm = 0;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_box();
		test_directed();
		test_backpressure();
		test_random();
		drain_clips();
		repeat (LATENCY + 8) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule

>>> segment_box_clipper.f
+incdir+sv
sv/sbc_pkg.sv
sv/sbc_if.sv
sv/sbc_front.sv
sv/sbc_div.sv
sv/sbc_round.sv
sv/segment_box_clipper.sv
verif/tb_top.sv
